/* hw/rtl/u8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

    // Field widths.
    localparam int CP_W    = 21;
    localparam int CNT_W   = 13;
    localparam int BYTE_W  = 8;

    // Hard ceiling on code points per string, and the reset value of max_count.
    localparam logic [CNT_W-1:0] COUNT_LIMIT     = 13'd4096;
    localparam logic [CNT_W-1:0] MAX_COUNT_RESET = 13'd4096;

    // Padded stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // Reason a string ended.
    typedef enum logic [1:0] {
        CAUSE_TERMINATOR = 2'd0,
        CAUSE_INVALID    = 2'd1,
        CAUSE_TRUNCATED  = 2'd2,
        CAUSE_LIMIT      = 2'd3
    } u8sd_cause_t;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0]       bytes_pending;
        logic [CP_W-1:0]  partial_value;
        logic [CNT_W-1:0] emitted_so_far;
        logic             discarding;
    } u8sd_state_t;

    // One result beat.
    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic             string_end;
        logic [CNT_W-1:0] decoded_count;
        u8sd_cause_t      stop_cause;
    } u8sd_result_t;

endpackage

`default_nettype wire

/* hw/rtl/u8sd_decode.sv */
// Per-byte next-state and result logic of the UTF-8 stream decoder.
`default_nettype none

module u8sd_decode
    import u8sd_pkg::*;
(
    input  wire u8sd_state_t       state,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic [CNT_W-1:0]  max_count,
    output u8sd_state_t            state_next,
    output logic                   result_valid,
    output u8sd_result_t           result
);

    logic [CNT_W-1:0] limit;
    logic             cp_done;
    logic [CP_W-1:0]  cp_value;
    logic [CP_W-1:0]  shifted;
    logic             end_req;
    logic             end_drop;
    u8sd_cause_t      end_cause;

    // Limit in force is the smaller of the register and the hard ceiling.
    assign limit   = (max_count > COUNT_LIMIT) ? COUNT_LIMIT : max_count;
    assign shifted = {state.partial_value[CP_W-7:0], text_byte[5:0]};

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        result       = '0;
        cp_done      = 1'b0;
        cp_value     = '0;
        end_req      = 1'b0;
        end_drop     = 1'b0;
        end_cause    = CAUSE_TERMINATOR;

        // Classify the byte against the current state.
        if (state.discarding)
        begin
            if (text_byte == '0)
            begin
                state_next = '0;
            end
        end
        else if (state.bytes_pending != 2'd0)
        begin
            if (text_byte == '0)
            begin
                end_req   = 1'b1;
                end_cause = CAUSE_TRUNCATED;
            end
            else
            begin
                state_next.partial_value = shifted;
                state_next.bytes_pending = state.bytes_pending - 2'd1;
                if (state.bytes_pending == 2'd1)
                begin
                    cp_done  = 1'b1;
                    cp_value = shifted;
                end
            end
        end
        else if (text_byte == '0)
        begin
            end_req   = 1'b1;
            end_cause = CAUSE_TERMINATOR;
        end
        else if (!text_byte[7])
        begin
            cp_done  = 1'b1;
            cp_value = {{(CP_W-BYTE_W){1'b0}}, text_byte};
        end
        else if (text_byte[7:5] == 3'b110)
        begin
            state_next.partial_value = {{(CP_W-5){1'b0}}, text_byte[4:0]};
            state_next.bytes_pending = 2'd1;
        end
        else if (text_byte[7:4] == 4'b1110)
        begin
            state_next.partial_value = {{(CP_W-4){1'b0}}, text_byte[3:0]};
            state_next.bytes_pending = 2'd2;
        end
        else if (text_byte[7:3] == 5'b11110)
        begin
            state_next.partial_value = {{(CP_W-3){1'b0}}, text_byte[2:0]};
            state_next.bytes_pending = 2'd3;
        end
        else
        begin
            end_req   = 1'b1;
            end_cause = CAUSE_INVALID;
            end_drop  = 1'b1;
        end

        // A completed code point goes out unless the string is at its limit.
        if (cp_done)
        begin
            if (state.emitted_so_far < limit)
            begin
                result_valid              = 1'b1;
                result.codepoint          = cp_value;
                state_next.emitted_so_far = state.emitted_so_far + 13'd1;
                state_next.partial_value  = '0;
            end
            else
            begin
                end_req   = 1'b1;
                end_cause = CAUSE_LIMIT;
                end_drop  = 1'b1;
            end
        end

        // End record: report count, clear state; discard on invalid/limit.
        if (end_req)
        begin
            result_valid         = 1'b1;
            result.string_end    = 1'b1;
            result.decoded_count = state.emitted_so_far;
            result.stop_cause    = end_cause;
            state_next           = '0;
            state_next.discarding = end_drop;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: state, configuration and output register.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] text_byte
//  m_axis    out        tdata[20:0] codepoint, [33:21] decoded_count; tlast string_end;
//                       tuser[1:0] stop_cause
//  cfg       in         cfg_wr_data = max_count, written when cfg_wr_en is high
//
// One input byte is taken per cycle; its result, if any, is in the output
// register on the next cycle. The decode of a byte is a single pass through
// the per-byte logic between the state registers and the output register.
// Input stalls only while the output register holds a beat that is not taken.
// Reset clears the string state and loads max_count with 4096.
`default_nettype none

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CNT_W-1:0]        cfg_wr_data,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] text_byte
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,   // [20:0] codepoint, [33:21] decoded_count
    output logic                         m_axis_tlast,   // string_end
    output logic [OUT_TUSER_W-1:0]       m_axis_tuser    // [1:0] stop_cause
);

    u8sd_state_t      state_reg;
    u8sd_state_t      state_next;
    logic [CNT_W-1:0] max_count_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    u8sd_result_t     out_reg;
    u8sd_result_t     dec_result;
    logic             dec_valid;
    logic             in_accept;

    // Per-byte decode.
    u8sd_decode u_decode (
        .state        (state_reg),
        .text_byte    (s_axis_tdata[BYTE_W-1:0]),
        .max_count    (max_count_reg),
        .state_next   (state_next),
        .result_valid (dec_valid),
        .result       (dec_result)
    );

    // Input is taken whenever the output register is empty or being drained.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Output register holds one beat.
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (in_accept && dec_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state: string state, limit register, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            max_count_reg <= MAX_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_wr_en)
            begin
                max_count_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded on each accepted byte that produces a beat.
    always_ff @(posedge clk)
    begin
        if (in_accept && dec_valid)
        begin
            out_reg <= dec_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-CP_W-CNT_W){1'b0}},
                            out_reg.decoded_count, out_reg.codepoint};
    assign m_axis_tlast  = out_reg.string_end;
    assign m_axis_tuser  = out_reg.stop_cause;

`ifndef ASSERT_OFF
    // End records never carry a code point.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[CP_W-1:0] == '0)
        else $error("end record carries a nonzero code point");

    // Code point beats carry no count and no cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tuser == '0 && m_axis_tdata[CP_W+CNT_W-1:CP_W] == '0)
        else $error("code point beat carries count or cause");

    // The per-string count never passes the hard ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.emitted_so_far <= COUNT_LIMIT)
        else $error("emitted count above limit");

    // A terminator byte always leaves a clean string state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_axis_tdata == '0 |=>
            state_reg.bytes_pending == 2'd0 && !state_reg.discarding &&
            state_reg.emitted_so_far == '0)
        else $error("string state not cleared after terminator");
`endif

endmodule

`default_nettype wire
